FILE: rtl/sliding_window_median_core_macros.svh
// Assertion macros shared by the sliding window median RTL.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

// Generic clocked check, held off while reset is asserted.
`define SWM_ASSERT(label, ck, rstn, prop, msg) \
  label: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error(msg);

// Same check on the module's own clk / rst_n.
`define SWM_ASSERT_CLK(label, prop, msg) `SWM_ASSERT(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/swm_pkg.sv
// Shared types and constants for the sliding window median core.
package swm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WIN_W  = 7;
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd3;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Cell state handed to the right-hand neighbor.
  typedef struct packed {
    sample_t value;
    logic    valid;
    logic    gt;     // held value sorts after the new sample (or empty)
    logic    ge;     // held value sorts at/after the outgoing sample (or empty)
  } swm_link_t;

  // Post-insert cell contents handed to the left-hand neighbor.
  typedef struct packed {
    sample_t value;
    logic    valid;
  } swm_ins_t;

endpackage

FILE: rtl/swm_in_if.sv
// Sample input channel: valid/ready handshake with one signed sample.
interface swm_in_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/swm_out_if.sv
// Median result channel: valid/ready handshake with one signed median.
interface swm_out_if;
  logic             valid;
  logic             ready;
  swm_pkg::sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

FILE: rtl/swm_cell.sv
// One slot of the sorted window row: insert-shift right, remove-shift left.
module swm_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                flush,
  input  logic                remove,
  input  swm_pkg::sample_t    sample,
  input  swm_pkg::sample_t    rm_sample,
  input  logic                ge_new,
  input  swm_pkg::swm_link_t  left_link,
  output swm_pkg::swm_link_t  right_link,
  input  swm_pkg::swm_ins_t   right_ins,
  output swm_pkg::swm_ins_t   own_ins
);

  swm_pkg::sample_t value_r;
  swm_pkg::sample_t value_nxt;
  logic             valid_r;
  logic             valid_nxt;
  logic             gt_self;
  logic             ge_self;
  logic             ins_ge;

  assign gt_self = !valid_r || (value_r > sample);
  assign ge_self = !valid_r || (value_r >= rm_sample);

  assign right_link = '{value: value_r, valid: valid_r, gt: gt_self, ge: ge_self};

  // Insert: keep own, take left neighbor's, or take the new sample.
  always_comb begin
    if (!gt_self) begin
      own_ins.value = value_r;
      own_ins.valid = valid_r;
      ins_ge        = ge_self;
    end else if (left_link.gt) begin
      own_ins.value = left_link.value;
      own_ins.valid = left_link.valid;
      ins_ge        = left_link.ge;
    end else begin
      own_ins.value = sample;
      own_ins.valid = 1'b1;
      ins_ge        = ge_new;
    end
  end

  // Remove: from the first entry equal to the outgoing sample on, pull from the right.
  always_comb begin
    if (remove && ins_ge) begin
      value_nxt = right_ins.value;
      valid_nxt = right_ins.valid;
    end else begin
      value_nxt = own_ins.value;
      valid_nxt = own_ins.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (flush) begin
      valid_r <= 1'b0;
    end else if (step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      value_r <= value_nxt;
    end
  end

endmodule

FILE: rtl/sliding_window_median_core.sv
// Top level of the sliding window median core.
// Running lower median over the last window_size signed 32-bit samples.
// Input channel in_chan carries one sample per item; output channel out_chan
// carries one median per item once the window is full, none before that.
// cfg_we/cfg_wdata set window_size (0 acts as 1, above MAX_WINDOW acts as
// MAX_WINDOW) and flush the window; write it only while the core is idle.
// Throughput: one sample per clock while the receiver keeps up. Each sample
// is inserted into a row of MAX_WINDOW sorted cells and the oldest sample,
// read from an arrival ring RAM, is removed in the same cycle; the median is
// registered and appears on out_chan in the cycle after its sample is accepted.
// The output register decouples the sides: in_chan.ready is high while the
// result register is empty or being taken. While a median waits on a stalled
// receiver, input stops, whether or not the next sample would make a result.
// Reset (synchronous, active low) empties the window, sets window_size to 3
// and drops any pending result; no clearing pass is needed.
`include "sliding_window_median_core_macros.svh"

module sliding_window_median_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [swm_pkg::WIN_W-1:0]  cfg_wdata,
  swm_in_if.sink                     in_chan,
  swm_out_if.source                  out_chan
);

  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SW = PW + 2;

  logic [swm_pkg::WIN_W-1:0] win_r;
  logic [FW-1:0]             fill_r;
  logic [FW-1:0]             fill_nxt;
  logic [PW-1:0]             oldest_r;
  logic [PW-1:0]             oldest_nxt;
  logic [PW-1:0]             oldest_inc;
  logic [FW-1:0]             eff_size;
  logic [FW-1:0]             count;
  logic [PW-1:0]             rank;
  logic [SW-1:0]             wr_sum;
  logic [PW-1:0]             wr_addr;
  logic                      accept;
  logic                      emit;
  swm_pkg::sample_t          rm_sample;
  swm_pkg::sample_t          rd_r;
  logic                      ge_new;
  logic                      out_vld_r;
  swm_pkg::sample_t          out_median_r;

  swm_pkg::sample_t          ring_mem [MAX_WINDOW];

  swm_pkg::swm_link_t        links   [MAX_WINDOW+1];
  swm_pkg::swm_ins_t         ins_row [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0]     cell_vld;
  logic [MAX_WINDOW-1:0]     order_ok;

  assign in_chan.ready   = !out_vld_r || out_chan.ready;
  assign accept          = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_vld_r;
  assign out_chan.median = out_median_r;

  always_comb begin
    if (win_r == '0) begin
      eff_size = FW'(1);
    end else if (int'(win_r) > int'(MAX_WINDOW)) begin
      eff_size = FW'(MAX_WINDOW);
    end else begin
      eff_size = FW'(win_r);
    end
  end

  assign rank  = PW'((eff_size - 1'b1) >> 1);
  assign count = fill_r + 1'b1;
  assign emit  = count >= eff_size;

  // Ring slot for the new sample: oldest + fill, wrapped once.
  assign wr_sum  = SW'(oldest_r) + SW'(fill_r);
  assign wr_addr = (wr_sum >= SW'(MAX_WINDOW)) ? PW'(wr_sum - SW'(MAX_WINDOW))
                                                 : PW'(wr_sum);

  assign oldest_inc = (int'(oldest_r) == int'(MAX_WINDOW) - 1) ? '0 : oldest_r + 1'b1;

  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    if (cfg_we) begin
      fill_nxt   = '0;
      oldest_nxt = '0;
    end else if (accept) begin
      fill_nxt   = emit ? fill_r : count;
      oldest_nxt = emit ? oldest_inc : oldest_r;
    end
  end

  // Empty window: the outgoing sample is the one just arriving.
  assign rm_sample = (fill_r == '0) ? in_chan.sample : rd_r;
  assign ge_new    = in_chan.sample >= rm_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= swm_pkg::WIN_RESET;
      fill_r   <= '0;
      oldest_r <= '0;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
    end
  end

  // Arrival ring; read port always tracks the next oldest slot, write-first.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[wr_addr] <= in_chan.sample;
    end
    if (accept && (wr_addr == oldest_nxt)) begin
      rd_r <= in_chan.sample;
    end else begin
      rd_r <= ring_mem[oldest_nxt];
    end
  end

  assign links[0]           = '{value: '0, valid: 1'b0, gt: 1'b0, ge: 1'b0};
  assign ins_row[MAX_WINDOW] = '{value: '0, valid: 1'b0};

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (accept && !cfg_we),
      .flush      (cfg_we),
      .remove     (emit),
      .sample     (in_chan.sample),
      .rm_sample  (rm_sample),
      .ge_new     (ge_new),
      .left_link  (links[i]),
      .right_link (links[i+1]),
      .right_ins  (ins_row[i+1]),
      .own_ins    (ins_row[i])
    );
    assign cell_vld[i] = links[i+1].valid;
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_order
    if (i + 1 < MAX_WINDOW) begin : g_pair
      assign order_ok[i] = !links[i+2].valid ||
                           (links[i+1].valid && (links[i+1].value <= links[i+2].value));
    end else begin : g_last
      assign order_ok[i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (accept && emit) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_median_r <= ins_row[FW'(rank)].value;
    end
  end

  `SWM_ASSERT_CLK(a_fill_below_max, (int'(fill_r) < int'(MAX_WINDOW)), "fill count reached capacity")
  `SWM_ASSERT_CLK(a_fill_matches_cells, ($countones(cell_vld) == int'(fill_r)), "occupied cells differ from fill count")
  `SWM_ASSERT_CLK(a_row_sorted, (&order_ok), "cell row not sorted or not packed")
  `SWM_ASSERT_CLK(a_fill_grows, (accept && !emit && !cfg_we |=> int'(fill_r) == int'($past(fill_r)) + 1), "fill count did not grow on a non-emitting item")
  `SWM_ASSERT_CLK(a_oldest_range, (int'(oldest_r) < int'(MAX_WINDOW)), "oldest pointer out of range")

endmodule
